### rtl/assert_macros.svh
// Assertion macros used by the RTL of the go-back-n receiver.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gbn_pkg.sv
// Types, codes and helper functions for the go-back-n receiver.
// Depends on nothing; used by go_back_n_receiver.
package gbn_pkg;

    localparam int unsigned MAX_PAYLOAD = 1024;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_WORD = 1'b1;

    localparam logic [2:0] LBL_FIRST  = 3'd0;
    localparam logic [2:0] LBL_SECOND = 3'd1;
    localparam logic [2:0] LBL_THIRD  = 3'd2;
    localparam logic [2:0] LBL_NAME   = 3'd3;
    localparam logic [2:0] LBL_DATA   = 3'd4;
    localparam logic [2:0] LBL_FINISH = 3'd5;
    localparam logic [2:0] LBL_ERROR  = 3'd6;
    localparam logic [2:0] LBL_NONE   = 3'd7;

    localparam logic [2:0] CFG_HS_TIMEOUT   = 3'd0;
    localparam logic [2:0] CFG_DATA_TIMEOUT = 3'd1;
    localparam logic [2:0] CFG_MAX_TRIES    = 3'd2;
    localparam logic [2:0] CFG_WINDOW_SIZE  = 3'd3;
    localparam logic [2:0] CFG_MAX_SERIAL   = 3'd4;

    typedef enum logic [5:0] {
        PH_IDLE       = 6'b000001,
        PH_WAIT_THIRD = 6'b000010,
        PH_WAIT_NAME  = 6'b000100,
        PH_RECV       = 6'b001000,
        PH_DONE       = 6'b010000,
        PH_FAILED     = 6'b100000
    } phase_t;

    typedef struct packed {
        logic        command;
        logic [15:0] packet_word;
        logic        last_word;
        logic [2:0]  label_code;
        logic [15:0] serial_number;
        logic [15:0] check_value;
        logic [10:0] payload_length;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  reply_label;
        logic [15:0] reply_serial;
        logic        deliver;
        logic [10:0] deliver_length;
        logic [2:0]  phase_now;
        logic        last_result;
    } out_item_t;

    function automatic logic [2:0] phase_num(input phase_t ph);
        logic [2:0] num;
        case (ph)
            PH_IDLE:       num = 3'd0;
            PH_WAIT_THIRD: num = 3'd1;
            PH_WAIT_NAME:  num = 3'd2;
            PH_RECV:       num = 3'd3;
            PH_DONE:       num = 3'd4;
            PH_FAILED:     num = 3'd5;
            default:       num = 3'd0;
        endcase
        return num;
    endfunction

    function automatic logic [15:0] fold_add(input logic [15:0] acc, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, w};
        return s[16] ? (s[15:0] + 16'd1) : s[15:0];
    endfunction

endpackage

### rtl/go_back_n_receiver.sv
// Top level of the go-back-n receiver: input register, protocol logic and result register.
// Depends on gbn_pkg and assert_macros.svh.
//
// Channel   Signals                                  Beat
// item      item_valid, item_ready, item             one packet word or one time tick
// result    result_valid, result_ready, result       one reply descriptor
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data one register write
//
// An accepted item sits in the input register while combinational logic computes its result,
// which is loaded into the result register once that register is free to take it.
// An item that gives one result lets the next item enter as it is processed, if the result register is free.
// Error and finish replies occupy the result register for three beats, which holds
// the input register for that time. Reset is asynchronous and active low; cfg is always ready.
`include "assert_macros.svh"

module go_back_n_receiver (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  gbn_pkg::in_item_t item,
    output logic              result_valid,
    input  logic              result_ready,
    output gbn_pkg::out_item_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    logic [15:0] hs_timeout_reg;
    logic [15:0] data_timeout_reg;
    logic [7:0]  max_tries_reg;
    logic [15:0] window_size_reg;
    logic [15:0] max_serial_reg;

    gbn_pkg::phase_t phase_reg, phase_next;
    logic [15:0] exp_reg, exp_next;
    logic [15:0] tick_reg, tick_next;
    logic [7:0]  tries_reg, tries_next;
    logic [15:0] sum_reg, sum_next;

    gbn_pkg::in_item_t item_reg;
    logic              item_valid_reg;

    gbn_pkg::out_item_t res_reg, res_next;
    logic               res_valid_reg;
    logic [1:0]         rep_reg, rep_next;

    logic        res_free;
    logic        proc_fire;
    logic        item_fire;
    logic [15:0] tick_inc;
    logic [15:0] total;
    logic        good;
    logic        serial_match;
    logic [15:0] back_dist;
    logic [10:0] keep_len;

    assign cfg_ready    = 1'b1;
    assign res_free     = !res_valid_reg || (result_ready && rep_reg == 2'd0);
    assign proc_fire    = item_valid_reg && res_free;
    assign item_ready   = !item_valid_reg || proc_fire;
    assign item_fire    = item_valid && item_ready;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign tick_inc     = (tick_reg != 16'hffff) ? tick_reg + 16'd1 : tick_reg;
    assign total        = gbn_pkg::fold_add(sum_reg, item_reg.packet_word);
    assign good         = item_reg.check_value == ~total;
    assign serial_match = item_reg.serial_number == exp_reg;
    assign back_dist    = exp_reg - item_reg.serial_number;
    assign keep_len     = (item_reg.payload_length > 11'(gbn_pkg::MAX_PAYLOAD)) ?
                          11'(gbn_pkg::MAX_PAYLOAD) : item_reg.payload_length;

    always_comb
    begin
        phase_next = phase_reg;
        exp_next   = exp_reg;
        tick_next  = tick_reg;
        tries_next = tries_reg;
        sum_next   = sum_reg;
        rep_next   = 2'd0;
        res_next   = '{reply_label: gbn_pkg::LBL_NONE, reply_serial: 16'd0, deliver: 1'b0,
                       deliver_length: 11'd0, phase_now: 3'd0, last_result: 1'b1};
        if (item_reg.command == gbn_pkg::CMD_TICK)
        begin
            tick_next = tick_inc;
            case (phase_reg)
                gbn_pkg::PH_WAIT_THIRD:
                begin
                    if (tries_reg > max_tries_reg)
                    begin
                        phase_next = gbn_pkg::PH_FAILED;
                        res_next.reply_label = gbn_pkg::LBL_ERROR;
                        rep_next = 2'd2;
                    end
                    else if (tick_inc > hs_timeout_reg)
                    begin
                        tick_next = 16'd0;
                        tries_next = (tries_reg != 8'hff) ? tries_reg + 8'd1 : tries_reg;
                        res_next.reply_label = gbn_pkg::LBL_SECOND;
                        res_next.reply_serial = window_size_reg;
                    end
                end
                gbn_pkg::PH_RECV:
                begin
                    if (tick_inc > data_timeout_reg)
                    begin
                        tick_next = 16'd0;
                        res_next.reply_label = gbn_pkg::LBL_DATA;
                        res_next.reply_serial = exp_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (!item_reg.last_word)
        begin
            sum_next = total;
        end
        else
        begin
            sum_next = 16'd0;
            case (phase_reg)
                gbn_pkg::PH_IDLE:
                begin
                    if (item_reg.label_code == gbn_pkg::LBL_FIRST)
                    begin
                        phase_next = gbn_pkg::PH_WAIT_THIRD;
                        tries_next = 8'd1;
                        tick_next = 16'd0;
                        res_next.reply_label = gbn_pkg::LBL_SECOND;
                        res_next.reply_serial = window_size_reg;
                    end
                end
                gbn_pkg::PH_WAIT_THIRD:
                begin
                    if (item_reg.label_code == gbn_pkg::LBL_THIRD)
                    begin
                        phase_next = gbn_pkg::PH_WAIT_NAME;
                        tries_next = 8'd0;
                        tick_next = 16'd0;
                    end
                    else if (tries_reg > max_tries_reg)
                    begin
                        phase_next = gbn_pkg::PH_FAILED;
                        res_next.reply_label = gbn_pkg::LBL_ERROR;
                        rep_next = 2'd2;
                    end
                end
                gbn_pkg::PH_WAIT_NAME:
                begin
                    if (item_reg.label_code == gbn_pkg::LBL_NAME && good)
                    begin
                        phase_next = gbn_pkg::PH_RECV;
                        exp_next = 16'd1;
                        tick_next = 16'd0;
                        res_next.reply_label = gbn_pkg::LBL_NAME;
                    end
                    else if (item_reg.label_code == gbn_pkg::LBL_ERROR)
                    begin
                        phase_next = gbn_pkg::PH_FAILED;
                        res_next.reply_label = gbn_pkg::LBL_ERROR;
                        rep_next = 2'd2;
                    end
                end
                gbn_pkg::PH_RECV:
                begin
                    if (item_reg.label_code == gbn_pkg::LBL_ERROR)
                    begin
                        phase_next = gbn_pkg::PH_FAILED;
                        res_next.reply_label = gbn_pkg::LBL_ERROR;
                        rep_next = 2'd2;
                    end
                    else if (item_reg.label_code == gbn_pkg::LBL_DATA && serial_match && good)
                    begin
                        exp_next = (exp_reg >= max_serial_reg) ? 16'd1 : exp_reg + 16'd1;
                        res_next.deliver = 1'b1;
                        res_next.deliver_length = keep_len;
                    end
                    else if (item_reg.label_code == gbn_pkg::LBL_FINISH && serial_match
                             && good)
                    begin
                        phase_next = gbn_pkg::PH_DONE;
                        res_next.reply_label = gbn_pkg::LBL_FINISH;
                        rep_next = 2'd2;
                    end
                    else if (tick_reg > data_timeout_reg || item_reg.serial_number > exp_reg
                             || back_dist > window_size_reg)
                    begin
                        tick_next = 16'd0;
                        res_next.reply_label = gbn_pkg::LBL_DATA;
                        res_next.reply_serial = exp_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
        res_next.phase_now = gbn_pkg::phase_num(phase_next);
        res_next.last_result = (rep_next == 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_timeout_reg   <= 16'd20;
            data_timeout_reg <= 16'd1000;
            max_tries_reg    <= 8'd10;
            window_size_reg  <= 16'd16;
            max_serial_reg   <= 16'hffff;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gbn_pkg::CFG_HS_TIMEOUT:   hs_timeout_reg   <= cfg_data;
                gbn_pkg::CFG_DATA_TIMEOUT: data_timeout_reg <= cfg_data;
                gbn_pkg::CFG_MAX_TRIES:    max_tries_reg    <= cfg_data[7:0];
                gbn_pkg::CFG_WINDOW_SIZE:  window_size_reg  <= cfg_data;
                gbn_pkg::CFG_MAX_SERIAL:   max_serial_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= gbn_pkg::PH_IDLE;
            exp_reg        <= 16'd1;
            tick_reg       <= 16'd0;
            tries_reg      <= 8'd0;
            sum_reg        <= 16'd0;
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
            rep_reg        <= 2'd0;
        end
        else
        begin
            if (item_fire)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (proc_fire)
            begin
                item_valid_reg <= 1'b0;
            end

            if (proc_fire)
            begin
                phase_reg     <= phase_next;
                exp_reg       <= exp_next;
                tick_reg      <= tick_next;
                tries_reg     <= tries_next;
                sum_reg       <= sum_next;
                res_valid_reg <= 1'b1;
                rep_reg       <= rep_next;
            end
            else if (res_valid_reg && result_ready)
            begin
                if (rep_reg == 2'd0)
                begin
                    res_valid_reg <= 1'b0;
                end
                else
                begin
                    rep_reg <= rep_reg - 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            item_reg <= item;
        end
        if (proc_fire)
        begin
            res_reg <= res_next;
        end
        else if (res_valid_reg && result_ready && rep_reg != 2'd0)
        begin
            res_reg.last_result <= (rep_reg == 2'd1);
        end
    end

    `ASSERT_SAME(a_rep_needs_valid, rep_reg != 2'd0, res_valid_reg, "repeat count without a result")
    `ASSERT_SAME(a_rep_label, res_valid_reg && rep_reg != 2'd0, res_reg.reply_label == gbn_pkg::LBL_ERROR || res_reg.reply_label == gbn_pkg::LBL_FINISH, "repeated reply is not error or finish")
    `ASSERT_SAME(a_deliver_silent, res_valid_reg && res_reg.deliver, res_reg.reply_label == gbn_pkg::LBL_NONE && res_reg.last_result, "delivery carries a reply")
    `ASSERT_NEXT(a_done_terminal, phase_reg == gbn_pkg::PH_DONE || phase_reg == gbn_pkg::PH_FAILED, $stable(phase_reg), "terminal phase left")

endmodule

### tb/sv/tb_go_back_n_receiver.sv
`timescale 1ns / 100ps
// Self-checking testbench for go_back_n_receiver: idle phase, handshake, name, in-order and random receive, and close.
// Depends on gbn_pkg and the RTL; expected replies come from a cycle-free protocol predictor.
module tb_go_back_n_receiver;

    typedef enum logic [2:0] {
        CONN_IDLE,
        CONN_WAIT_THIRD,
        CONN_WAIT_NAME,
        CONN_RECV,
        CONN_DONE,
        CONN_FAILED
    } conn_state_t;

    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 8;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    gbn_pkg::in_item_t  item;
    logic               result_valid;
    logic               result_ready = 1'b0;
    gbn_pkg::out_item_t result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;

    logic [15:0] hs_timeout_reg;
    logic [15:0] data_timeout_reg;
    logic [7:0]  max_tries_reg;
    logic [15:0] window_reg;
    logic [15:0] max_serial_reg;

    conn_state_t conn_state;
    logic [15:0] next_serial;
    logic [15:0] idle_ticks;
    logic [7:0]  tries_sent;
    logic [15:0] word_sum;

    gbn_pkg::out_item_t step_replies[$];
    gbn_pkg::out_item_t expected_replies[$];
    int failures = 0;
    int items_sent = 0;
    int send_idle_pct = 25;
    int recv_idle_pct = 87;

    go_back_n_receiver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(3_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    function automatic void reset_model();
        hs_timeout_reg   = 16'd20;
        data_timeout_reg = 16'd1000;
        max_tries_reg    = 8'd10;
        window_reg       = 16'd16;
        max_serial_reg   = 16'hffff;
        conn_state       = CONN_IDLE;
        next_serial      = 16'd1;
        idle_ticks       = 16'd0;
        tries_sent       = 8'd0;
        word_sum         = 16'd0;
    endfunction

    function automatic void add_reply(input logic [2:0] label, input logic [15:0] serial,
                                      input logic del, input logic [10:0] len);
        gbn_pkg::out_item_t r;
        r = '0;
        r.reply_label    = label;
        r.reply_serial   = serial;
        r.deliver        = del;
        r.deliver_length = len;
        step_replies.push_back(r);
    endfunction

    function automatic void add_reply_thrice(input logic [2:0] label);
        repeat (3) add_reply(label, 16'd0, 1'b0, 11'd0);
    endfunction

    function automatic void add_ack();
        idle_ticks = 16'd0;
        add_reply(gbn_pkg::LBL_DATA, next_serial, 1'b0, 11'd0);
    endfunction

    function automatic void predict_replies(input gbn_pkg::in_item_t it);
        logic [15:0]        total;
        logic               good;
        logic [10:0]        keep;
        gbn_pkg::out_item_t r;
        step_replies.delete();
        if (it.command == gbn_pkg::CMD_TICK)
        begin
            if (idle_ticks != 16'hffff)
                idle_ticks++;
            if (conn_state == CONN_WAIT_THIRD)
            begin
                if (tries_sent > max_tries_reg)
                begin
                    conn_state = CONN_FAILED;
                    add_reply_thrice(gbn_pkg::LBL_ERROR);
                end
                else if (idle_ticks > hs_timeout_reg)
                begin
                    idle_ticks = 16'd0;
                    if (tries_sent != 8'hff)
                        tries_sent++;
                    add_reply(gbn_pkg::LBL_SECOND, window_reg, 1'b0, 11'd0);
                end
            end
            else if (conn_state == CONN_RECV && idle_ticks > data_timeout_reg)
                add_ack();
        end
        else
        begin
            total = ones_add(word_sum, it.packet_word);
            if (!it.last_word)
                word_sum = total;
            else
            begin
                good = (it.check_value == ~total);
                word_sum = 16'd0;
                case (conn_state)
                    CONN_IDLE:
                        if (it.label_code == gbn_pkg::LBL_FIRST)
                        begin
                            conn_state = CONN_WAIT_THIRD;
                            tries_sent = 8'd1;
                            idle_ticks = 16'd0;
                            add_reply(gbn_pkg::LBL_SECOND, window_reg, 1'b0, 11'd0);
                        end
                    CONN_WAIT_THIRD:
                        if (it.label_code == gbn_pkg::LBL_THIRD)
                        begin
                            conn_state = CONN_WAIT_NAME;
                            tries_sent = 8'd0;
                            idle_ticks = 16'd0;
                        end
                        else if (tries_sent > max_tries_reg)
                        begin
                            conn_state = CONN_FAILED;
                            add_reply_thrice(gbn_pkg::LBL_ERROR);
                        end
                    CONN_WAIT_NAME:
                        if (it.label_code == gbn_pkg::LBL_NAME && good)
                        begin
                            conn_state = CONN_RECV;
                            next_serial = 16'd1;
                            idle_ticks = 16'd0;
                            add_reply(gbn_pkg::LBL_NAME, 16'd0, 1'b0, 11'd0);
                        end
                        else if (it.label_code == gbn_pkg::LBL_ERROR)
                        begin
                            conn_state = CONN_FAILED;
                            add_reply_thrice(gbn_pkg::LBL_ERROR);
                        end
                    CONN_RECV:
                        if (it.label_code == gbn_pkg::LBL_ERROR)
                        begin
                            conn_state = CONN_FAILED;
                            add_reply_thrice(gbn_pkg::LBL_ERROR);
                        end
                        else if (it.label_code == gbn_pkg::LBL_DATA
                                 && it.serial_number == next_serial && good)
                        begin
                            keep = (it.payload_length > gbn_pkg::MAX_PAYLOAD)
                                   ? 11'(gbn_pkg::MAX_PAYLOAD) : it.payload_length;
                            next_serial = (next_serial >= max_serial_reg) ? 16'd1
                                                                           : next_serial + 16'd1;
                            add_reply(gbn_pkg::LBL_NONE, 16'd0, 1'b1, keep);
                        end
                        else if (it.label_code == gbn_pkg::LBL_FINISH
                                 && it.serial_number == next_serial && good)
                        begin
                            conn_state = CONN_DONE;
                            add_reply_thrice(gbn_pkg::LBL_FINISH);
                        end
                        else if (idle_ticks > data_timeout_reg
                                 || it.serial_number > next_serial
                                 || (next_serial - it.serial_number) > window_reg)
                            add_ack();
                    default: ;
                endcase
            end
        end
        if (step_replies.size() == 0)
            add_reply(gbn_pkg::LBL_NONE, 16'd0, 1'b0, 11'd0);
        foreach (step_replies[i])
        begin
            r = step_replies[i];
            r.phase_now   = conn_state;
            r.last_result = (i == step_replies.size() - 1);
            expected_replies.push_back(r);
        end
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        gbn_pkg::out_item_t want;
        if (!rst_n)
            result_ready <= 1'b0;
        else
        begin
            result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (result_valid && result_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    $error("result beat with no reply expected");
                    failures++;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    check_field("reply_label", 16'(want.reply_label),
                                16'(result.reply_label));
                    check_field("reply_serial", want.reply_serial, result.reply_serial);
                    check_field("deliver", 16'(want.deliver), 16'(result.deliver));
                    check_field("deliver_length", 16'(want.deliver_length),
                                16'(result.deliver_length));
                    check_field("phase_now", 16'(want.phase_now), 16'(result.phase_now));
                    check_field("last_result", 16'(want.last_result),
                                16'(result.last_result));
                end
            end
        end
    end

    function automatic gbn_pkg::in_item_t random_item();
        gbn_pkg::in_item_t it;
        it.command        = 1'($urandom);
        it.packet_word    = 16'($urandom);
        it.last_word      = 1'($urandom);
        it.label_code     = 3'($urandom);
        it.serial_number  = 16'($urandom);
        it.check_value    = 16'($urandom);
        it.payload_length = 11'($urandom);
        return it;
    endfunction

    function automatic logic [10:0] rand_length();
        if ($urandom_range(0, 4) == 0)
            return 11'($urandom);
        return 11'($urandom_range(0, gbn_pkg::MAX_PAYLOAD));
    endfunction

    function automatic logic [15:0] pick_setting(input int hi);
        case ($urandom_range(0, 3))
            0:       return 16'd1;
            1:       return 16'hffff;
            default: return 16'($urandom_range(1, hi));
        endcase
    endfunction

    task automatic send_item(input gbn_pkg::in_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predict_replies(it);
        items_sent++;
    endtask

    task automatic send_tick();
        gbn_pkg::in_item_t it;
        it = random_item();
        it.command = gbn_pkg::CMD_TICK;
        send_item(it);
    endtask

    task automatic send_stray_word(input logic [15:0] w);
        gbn_pkg::in_item_t it;
        it = random_item();
        it.command     = gbn_pkg::CMD_WORD;
        it.packet_word = w;
        it.last_word   = 1'b0;
        send_item(it);
    endtask

    // The checksum of the closing beat covers every word folded since the last packet.
    task automatic send_packet(input logic [2:0] label, input logic [15:0] serial,
                               input int nwords, input logic good, input logic [10:0] plen);
        gbn_pkg::in_item_t it;
        logic [15:0] total;
        for (int i = 0; i < nwords; i++)
        begin
            it = random_item();
            it.command   = gbn_pkg::CMD_WORD;
            it.last_word = (i == nwords - 1);
            if (it.last_word)
            begin
                total = ones_add(word_sum, it.packet_word);
                it.label_code     = label;
                it.serial_number  = serial;
                it.payload_length = plen;
                it.check_value    = good ? ~total : ~total ^ 16'($urandom_range(1, 65535));
            end
            send_item(it);
        end
    endtask

    task automatic wait_drained();
        int waited;
        item_valid <= 1'b0;
        waited = 0;
        while (expected_replies.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_replies.size() != 0)
        begin
            $error("%0d expected replies never arrived", expected_replies.size());
            failures++;
            expected_replies.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            gbn_pkg::CFG_HS_TIMEOUT:   hs_timeout_reg   = data;
            gbn_pkg::CFG_DATA_TIMEOUT: data_timeout_reg = data;
            gbn_pkg::CFG_MAX_TRIES:    max_tries_reg    = data[7:0];
            gbn_pkg::CFG_WINDOW_SIZE:  window_reg       = data;
            gbn_pkg::CFG_MAX_SERIAL:   max_serial_reg   = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_idle_phase();
        send_tick();
        send_stray_word(16'hffff);
        send_stray_word(16'hffff);
        send_packet(gbn_pkg::LBL_THIRD, 16'hffff, 1, 1'b1, 11'h7ff);
        send_packet(gbn_pkg::LBL_DATA, 16'd0, 1, 1'b0, 11'd0);
        send_packet(gbn_pkg::LBL_ERROR, 16'd1, 2, 1'b1, 11'd1024);
        send_packet(gbn_pkg::LBL_NONE, 16'h8000, 1, 1'b1, 11'd1025);
        send_packet(gbn_pkg::LBL_FIRST, 16'd0, 2, 1'b1, 11'd0);
    endtask

    task automatic test_handshake();
        wait_drained();
        write_reg(gbn_pkg::CFG_HS_TIMEOUT, 16'hffff);
        write_reg(gbn_pkg::CFG_MAX_TRIES, 16'h12ff);
        write_reg(gbn_pkg::CFG_WINDOW_SIZE, 16'hffff);
        send_tick();
        send_tick();
        wait_drained();
        write_reg(gbn_pkg::CFG_HS_TIMEOUT, 16'd1);
        repeat (4) send_tick();
        send_packet(gbn_pkg::LBL_DATA, 16'd1, 1, 1'b1, 11'd0);
        send_packet(gbn_pkg::LBL_THIRD, 16'd0, 1, 1'b0, 11'd0);
    endtask

    task automatic test_name_phase();
        send_packet(gbn_pkg::LBL_NAME, 16'd0, 2, 1'b0, 11'd0);
        send_tick();
        send_packet(gbn_pkg::LBL_DATA, 16'd1, 1, 1'b1, 11'd0);
        send_packet(gbn_pkg::LBL_NAME, 16'd0, 3, 1'b1, 11'd12);
    endtask

    task automatic test_receive_directed();
        wait_drained();
        write_reg(gbn_pkg::CFG_DATA_TIMEOUT, 16'hffff);
        write_reg(gbn_pkg::CFG_WINDOW_SIZE, 16'd16);
        write_reg(gbn_pkg::CFG_MAX_TRIES, 16'd1);
        send_packet(gbn_pkg::LBL_DATA, next_serial, 1, 1'b1, 11'd0);
        send_packet(gbn_pkg::LBL_DATA, next_serial, 2, 1'b1, 11'h7ff);
        send_packet(gbn_pkg::LBL_DATA, next_serial, 1, 1'b0, 11'd100);
        send_packet(gbn_pkg::LBL_DATA, 16'hffff, 1, 1'b1, 11'd1);
        send_packet(gbn_pkg::LBL_DATA, 16'd0, 1, 1'b1, 11'd1);
        wait_drained();
        write_reg(gbn_pkg::CFG_MAX_SERIAL, 16'd1);
        send_packet(gbn_pkg::LBL_DATA, next_serial, 1, 1'b1, 11'd1024);
        send_packet(gbn_pkg::LBL_DATA, next_serial, 1, 1'b1, 11'd1025);
    endtask

    task automatic random_action();
        int pick;
        logic [15:0] serial;
        logic [2:0] label;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            send_packet(gbn_pkg::LBL_DATA, next_serial, $urandom_range(1, 3), 1'b1,
                        rand_length());
        else if (pick < 70)
            repeat ($urandom_range(1, 4)) send_tick();
        else if (pick < 82)
        begin
            case ($urandom_range(0, 3))
                0:       serial = next_serial + 16'($urandom_range(1, 3));
                1:       serial = next_serial - 16'($urandom_range(1, 20));
                2:       serial = 16'($urandom);
                default: serial = next_serial;
            endcase
            send_packet(gbn_pkg::LBL_DATA, serial, $urandom_range(1, 3),
                        (serial != next_serial) && $urandom_range(0, 1), rand_length());
        end
        else if (pick < 92)
        begin
            case ($urandom_range(0, 5))
                0:       label = gbn_pkg::LBL_FIRST;
                1:       label = gbn_pkg::LBL_SECOND;
                2:       label = gbn_pkg::LBL_THIRD;
                3:       label = gbn_pkg::LBL_NAME;
                4:       label = gbn_pkg::LBL_FINISH;
                default: label = gbn_pkg::LBL_NONE;
            endcase
            send_packet(label, 16'($urandom), $urandom_range(1, 2),
                        (label != gbn_pkg::LBL_FINISH) && $urandom_range(0, 1), rand_length());
        end
        else
            send_stray_word(16'($urandom));
    endtask

    task automatic test_random_receive();
        int stop_at;
        for (int regime = 0; regime < 3; regime++)
        begin
            case (regime)
                0:
                begin
                    send_idle_pct = 25;
                    recv_idle_pct = 87;
                end
                1:
                begin
                    send_idle_pct = 87;
                    recv_idle_pct = 25;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 4; seg++)
            begin
                wait_drained();
                write_reg(gbn_pkg::CFG_DATA_TIMEOUT, pick_setting(30));
                write_reg(gbn_pkg::CFG_WINDOW_SIZE, pick_setting(20));
                write_reg(gbn_pkg::CFG_MAX_SERIAL, pick_setting(12));
                stop_at = items_sent + 32;
                while (items_sent < stop_at)
                    random_action();
            end
        end
    endtask

    task automatic test_close();
        wait_drained();
        send_idle_pct = 25;
        recv_idle_pct = 87;
        if ($urandom_range(0, 1))
            send_packet(gbn_pkg::LBL_FINISH, next_serial, 2, 1'b1, 11'd0);
        else
            send_packet(gbn_pkg::LBL_ERROR, 16'($urandom), 1, 1'b0, 11'd0);
        send_tick();
        send_packet(gbn_pkg::LBL_DATA, next_serial, 1, 1'b1, 11'd5);
        send_packet(gbn_pkg::LBL_FIRST, 16'd0, 1, 1'b1, 11'd0);
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= gbn_pkg::CFG_HS_TIMEOUT;
        cfg_data   <= 16'd0;
        reset_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_phase();
        test_handshake();
        test_name_phase();
        test_receive_directed();
        test_random_receive();
        test_close();
        wait_drained();
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
